[sv/emrp_pkg.sv]
// Shared codes and field widths for the exponent/mantissa range packer.
`timescale 1ns / 1ps

package emrp_pkg;

    // Item kind codes
    localparam logic KIND_PACK   = 1'b0;
    localparam logic KIND_UNPACK = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_ROUNDED_UP   = 2'd1;
    localparam logic [1:0] STATUS_ROUNDED_DOWN = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALUE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP      = 2'd2;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int WORD_W  = 16;

    // Reset values of the configuration registers
    localparam logic [VALUE_W-1:0] MIN_VALUE_RESET = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] SCALE_RESET     = 32'h0001_0000;
    localparam logic [VALUE_W-1:0] STEP_RESET      = 32'h0001_0000;

endpackage

[sv/exponent_mantissa_range_packer.sv]
// Exponent/mantissa range packer: six-stage pack and unpack datapath.
// Throughput: one item per cycle while the output is not stalled; the depth is set by the 32x32 multiply stage
//   and the leading-one search and shifts around it.
// A stalled output holds each full stage with no empty stage after it; empty stages are filled while stalled.
// Reset clears all stage valid bits; min_value resets to 0, scale and step to 1.0.
`timescale 1ns / 1ps

module exponent_mantissa_range_packer #(
    parameter int PACKED_BITS  = 16,
    parameter int MAX_EXPONENT = 15
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [emrp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                          cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic signed [emrp_pkg::VALUE_W-1:0]  value,
    input  logic [emrp_pkg::WORD_W-1:0]          packed_word,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [emrp_pkg::WORD_W-1:0]          packed_out,
    output logic signed [emrp_pkg::VALUE_W-1:0]  value_out,
    output logic [1:0]                           status
);

    // Word layout
    localparam int ME      = MAX_EXPONENT;
    localparam int EB      = $clog2(ME + 1);
    localparam int MB      = (PACKED_BITS > EB) ? (PACKED_BITS - EB) : 0;
    localparam int S       = MB + 1;
    localparam int STAGES  = 6;

    localparam logic [63:0] MAN_MASK  = (64'd1 << MB) - 64'd1;
    localparam logic [63:0] K_BIAS    = 64'd2 << MB;
    localparam logic [64:0] HALF      = 65'd1 << MB;
    localparam logic [64:0] ONE_Q32   = 65'd1 << 32;
    localparam logic [64:0] SAT_LIM   = 65'd1 << (33 + ME);
    localparam logic [63:0] OFF_MAX   = 64'd1 << 33;
    localparam logic [6:0]  SHIFT_BASE = 7'(32 - MB);
    localparam logic [4:0]  E_MAX     = 5'(ME);

    // Configuration registers
    logic signed [31:0] min_value_reg;
    logic [31:0]        scale_reg;
    logic [31:0]        step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg <= emrp_pkg::MIN_VALUE_RESET;
            scale_reg     <= emrp_pkg::SCALE_RESET;
            step_reg      <= emrp_pkg::STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                emrp_pkg::REG_MIN_VALUE: min_value_reg <= cfg_data;
                emrp_pkg::REG_SCALE:     scale_reg     <= cfg_data;
                emrp_pkg::REG_STEP:      step_reg      <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Stage valid bits and load enables; a stage loads when empty or draining
    logic [STAGES:1] valid_reg;
    logic [STAGES:1] kind_reg;
    logic [STAGES:1] en;

    always_comb
    begin
        en[STAGES] = !valid_reg[STAGES] || out_ready;
        for (int i = STAGES - 1; i >= 1; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int i = 2; i <= STAGES; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            kind_reg[1] <= kind;
        end
        for (int i = 2; i <= STAGES; i++)
        begin
            if (en[i])
            begin
                kind_reg[i] <= kind_reg[i-1];
            end
        end
    end

    // Stage 1: pack offset from range start, or unpack shifted mantissa term
    logic        neg1_reg, neg1_next;
    logic [63:0] data1_reg, data1_next;

    always_comb
    begin
        logic [32:0]      diff;
        logic [EB-1:0]    e_in;
        logic [63:0]      m_in;
        logic [63:0]      k_in;
        diff = {value[31], value} - {min_value_reg[31], min_value_reg};
        e_in = packed_word[EB-1:0];
        m_in = (64'(packed_word) >> EB) & MAN_MASK;
        k_in = K_BIAS + (m_in << 1) + 64'd1;
        if (kind == emrp_pkg::KIND_UNPACK)
        begin
            data1_next = k_in << e_in;
            neg1_next  = 1'b0;
        end
        else
        begin
            data1_next = {32'd0, diff[31:0]};
            neg1_next  = diff[32];
        end
    end

    // Stage 2: unpack numerator n = k * 2^e - 2^(MB+1)
    logic        neg2_reg;
    logic [63:0] data2_reg, data2_next;

    always_comb
    begin
        if (kind_reg[1] == emrp_pkg::KIND_UNPACK)
        begin
            data2_next = data1_reg - K_BIAS;
        end
        else
        begin
            data2_next = data1_reg;
        end
    end

    // Stage 3: multiplies; the low multiplier is shared by both kinds
    logic        neg3_reg;
    logic [63:0] lo3_reg, lo3_next;
    logic [63:0] hi3_reg, hi3_next;

    always_comb
    begin
        logic [31:0] mul_a;
        logic [31:0] mul_b;
        if (kind_reg[2] == emrp_pkg::KIND_UNPACK)
        begin
            mul_a = data2_reg[31:0];
            mul_b = step_reg;
        end
        else
        begin
            mul_a = neg2_reg ? 32'd0 : data2_reg[31:0];
            mul_b = scale_reg;
        end
        lo3_next = mul_a * mul_b;
        hi3_next = data2_reg[63:32] * step_reg;
    end

    // Stage 4: pack renorm = 1 + prod with range check; unpack rounding add
    logic [1:0]  stat4_reg, stat4_next;
    logic [63:0] acc4_reg, acc4_next;
    logic [63:0] hi4_reg, hi4_next;

    always_comb
    begin
        logic [64:0] sum;
        sum       = {1'b0, lo3_reg} + ((kind_reg[3] == emrp_pkg::KIND_UNPACK) ? HALF : ONE_Q32);
        acc4_next = sum[63:0];
        hi4_next  = {hi3_reg[63:32] + 32'(sum[64]), hi3_reg[31:0]};
        if (kind_reg[3] == emrp_pkg::KIND_UNPACK)
        begin
            stat4_next = emrp_pkg::STATUS_OK;
        end
        else if (neg3_reg)
        begin
            stat4_next = (scale_reg != 32'd0) ? emrp_pkg::STATUS_ROUNDED_UP
                                              : emrp_pkg::STATUS_OK;
        end
        else if (sum >= SAT_LIM)
        begin
            stat4_next = emrp_pkg::STATUS_ROUNDED_DOWN;
        end
        else
        begin
            stat4_next = emrp_pkg::STATUS_OK;
        end
    end

    // Stage 5: pack leading-one search; unpack offset scaling and clamp
    logic [1:0]  stat5_reg;
    logic [63:0] acc5_reg;
    logic [4:0]  e5_reg, e5_next;
    logic [33:0] off5_reg, off5_next;

    always_comb
    begin
        logic [4:0]  idx;
        logic [63:0] off_sum;
        idx = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (acc4_reg[32+i])
            begin
                idx = 5'(i);
            end
        end
        e5_next = (stat4_reg == emrp_pkg::STATUS_ROUNDED_DOWN) ? E_MAX : idx;

        off_sum = (hi4_reg << (32 - S)) + (acc4_reg >> S);
        if ((hi4_reg >> S) != 64'd0 || off_sum > OFF_MAX)
        begin
            off5_next = OFF_MAX[33:0];
        end
        else
        begin
            off5_next = off_sum[33:0];
        end
    end

    // Stage 6: output register; mantissa extract or final add with saturation
    logic [emrp_pkg::WORD_W-1:0]  packed_out_reg, packed_out_next;
    logic [emrp_pkg::VALUE_W-1:0] value_out_reg, value_out_next;
    logic [1:0]                   status_reg, status_next;

    always_comb
    begin
        logic [63:0]        man;
        logic [63:0]        word;
        logic signed [34:0] vsum;
        if (stat5_reg == emrp_pkg::STATUS_ROUNDED_DOWN)
        begin
            man = MAN_MASK;
        end
        else
        begin
            man = (acc5_reg >> (7'(e5_reg) + SHIFT_BASE)) & MAN_MASK;
        end
        word = 64'(e5_reg) | (man << EB);
        vsum = {{3{min_value_reg[31]}}, min_value_reg} + {1'b0, off5_reg};

        if (kind_reg[5] == emrp_pkg::KIND_UNPACK)
        begin
            packed_out_next = '0;
            if (vsum > 35'sd2147483647)
            begin
                value_out_next = 32'h7FFF_FFFF;
                status_next    = emrp_pkg::STATUS_ROUNDED_DOWN;
            end
            else
            begin
                value_out_next = vsum[31:0];
                status_next    = emrp_pkg::STATUS_OK;
            end
        end
        else
        begin
            packed_out_next = word[emrp_pkg::WORD_W-1:0];
            value_out_next  = '0;
            status_next     = stat5_reg;
        end
    end

    // Stage payload registers
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            neg1_reg  <= neg1_next;
            data1_reg <= data1_next;
        end
        if (en[2])
        begin
            neg2_reg  <= neg1_reg;
            data2_reg <= data2_next;
        end
        if (en[3])
        begin
            neg3_reg <= neg2_reg;
            lo3_reg  <= lo3_next;
            hi3_reg  <= hi3_next;
        end
        if (en[4])
        begin
            stat4_reg <= stat4_next;
            acc4_reg  <= acc4_next;
            hi4_reg   <= hi4_next;
        end
        if (en[5])
        begin
            stat5_reg <= stat4_reg;
            acc5_reg  <= acc4_reg;
            e5_reg    <= e5_next;
            off5_reg  <= off5_next;
        end
        if (en[6])
        begin
            packed_out_reg <= packed_out_next;
            value_out_reg  <= value_out_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid  = valid_reg[STAGES];
    assign packed_out = packed_out_reg;
    assign value_out  = value_out_reg;
    assign status     = status_reg;

    // Checks
    localparam logic [63:0] SAT_WORD64 = 64'(ME) | (MAN_MASK << EB);

    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline stalled input while output was drained");

    a_rounded_up_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == emrp_pkg::STATUS_ROUNDED_UP
            |-> packed_out == '0 && value_out == '0)
        else $error("below-range result carries a nonzero word");

    a_pack_saturation_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind_reg[STAGES] == emrp_pkg::KIND_PACK
            && status == emrp_pkg::STATUS_ROUNDED_DOWN
            |-> packed_out == SAT_WORD64[emrp_pkg::WORD_W-1:0])
        else $error("above-range pack result is not the top code");

    a_unpack_saturation_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind_reg[STAGES] == emrp_pkg::KIND_UNPACK
            && status == emrp_pkg::STATUS_ROUNDED_DOWN
            |-> value_out == 32'sh7FFF_FFFF && packed_out == '0)
        else $error("saturated unpack result has wrong value");

endmodule

[bench/exponent_mantissa_range_packer_tb.sv]
// Self-checking testbench for the exponent/mantissa range packer.
`timescale 1ns / 1ps

module exponent_mantissa_range_packer_tb;

    localparam int PACKED_W  = 16;
    localparam int MAX_EXP   = 15;
    localparam int EXP_W     = $clog2(MAX_EXP + 1);
    localparam int MAN_W     = PACKED_W - EXP_W;
    // Products at or above this push the exponent past MAX_EXP
    localparam logic [63:0] SAT_LIMIT = (64'hFFFF_FFFF_FFFF_FFFF >> (31 - MAX_EXP))
                                        - 64'hFFFF_FFFF;
    localparam logic [63:0] OFFSET_CAP = 64'd1 << 33;
    localparam longint VALUE_MAX = 64'sd2147483647;
    localparam longint VALUE_MIN = -64'sd2147483648;
    // Index with no register behind it
    localparam logic [emrp_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RAND_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int HOLD_PHASE = 3;
    localparam int HOLD_LEN = 80;

    typedef struct packed {
        logic                                kind;
        logic signed [emrp_pkg::VALUE_W-1:0] value;
        logic [emrp_pkg::WORD_W-1:0]         packed_word;
    } pack_item_t;

    typedef struct packed {
        logic [emrp_pkg::WORD_W-1:0]         packed_out;
        logic signed [emrp_pkg::VALUE_W-1:0] value_out;
        logic [1:0]                          status;
    } pack_result_t;

    // Register shadow, packing predictor and queue of expected result beats
    class packer_scoreboard;
        logic signed [emrp_pkg::VALUE_W-1:0] min_value;
        logic [emrp_pkg::VALUE_W-1:0]        scale;
        logic [emrp_pkg::VALUE_W-1:0]        step;
        pack_result_t                        expected_results[$];
        int                                  fail_count;

        function new();
            min_value  = emrp_pkg::MIN_VALUE_RESET;
            scale      = emrp_pkg::SCALE_RESET;
            step       = emrp_pkg::STEP_RESET;
            fail_count = 0;
        endfunction

        function void write_reg(logic [emrp_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
            case (idx)
                emrp_pkg::REG_MIN_VALUE: min_value = data;
                emrp_pkg::REG_SCALE:     scale = data;
                emrp_pkg::REG_STEP:      step = data;
                default: ;
            endcase
        endfunction

        function pack_result_t packed_or_rebuilt(pack_item_t it);
            pack_result_t     res;
            longint           diff;
            longint           rebuilt;
            logic [63:0]      udiff;
            logic [63:0]      prod;
            logic [63:0]      renorm;
            logic [63:0]      mant;
            logic [63:0]      n;
            logic [63:0]      off;
            logic [EXP_W-1:0] e;
            logic [MAN_W-1:0] m;
            int               pos;

            res = '0;
            if (it.kind == emrp_pkg::KIND_PACK) begin
                e = '0;
                m = '0;
                diff = longint'($signed(it.value)) - longint'(min_value);
                if (diff < 0) begin
                    // below range: clamp renorm to one
                    if (scale != 0)
                        res.status = emrp_pkg::STATUS_ROUNDED_UP;
                end else begin
                    udiff = diff;
                    prod = udiff * {32'd0, scale};
                    if (prod >= SAT_LIMIT) begin
                        e = EXP_W'(MAX_EXP);
                        m = '1;
                        res.status = emrp_pkg::STATUS_ROUNDED_DOWN;
                    end else begin
                        renorm = (64'd1 << 32) + prod;
                        pos = 63;
                        while (!renorm[pos])
                            pos--;
                        e = EXP_W'(pos - 32);
                        mant = renorm >> (pos - MAN_W);
                        m = mant[MAN_W-1:0];
                    end
                end
                res.packed_out = {m, e};
            end else begin
                e = it.packed_word[EXP_W-1:0];
                m = it.packed_word[emrp_pkg::WORD_W-1:EXP_W];
                // bin center in units of 2^-(MAN_W+1), minus the implicit one
                n = (((64'd2 << MAN_W) + (64'(m) << 1) + 64'd1) << e) - (64'd2 << MAN_W);
                off = ({32'd0, step} * n + (64'd1 << MAN_W)) >> (MAN_W + 1);
                if (off > OFFSET_CAP)
                    off = OFFSET_CAP;
                rebuilt = longint'(min_value) + longint'(off);
                if (rebuilt > VALUE_MAX) begin
                    rebuilt = VALUE_MAX;
                    res.status = emrp_pkg::STATUS_ROUNDED_DOWN;
                end
                res.value_out = rebuilt[31:0];
            end
            return res;
        endfunction

        function void note_item(pack_item_t it);
            expected_results.push_back(packed_or_rebuilt(it));
        endfunction

        function void check_result(logic [emrp_pkg::WORD_W-1:0] p,
                                   logic [emrp_pkg::VALUE_W-1:0] v, logic [1:0] s);
            pack_result_t want;
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: packed_out %h value_out %h status %0d",
                       p, v, s);
                fail_count++;
                return;
            end
            want = expected_results.pop_front();
            if (p !== want.packed_out) begin
                $error("packed_out: expected %h, got %h", want.packed_out, p);
                fail_count++;
            end
            if (v !== want.value_out) begin
                $error("value_out: expected %h, got %h", want.value_out, v);
                fail_count++;
            end
            if (s !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, s);
                fail_count++;
            end
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [emrp_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [31:0]                         cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic                                kind;
    logic signed [emrp_pkg::VALUE_W-1:0] value;
    logic [emrp_pkg::WORD_W-1:0]         packed_word;
    logic                                out_valid;
    logic                                out_ready;
    logic [emrp_pkg::WORD_W-1:0]         packed_out;
    logic signed [emrp_pkg::VALUE_W-1:0] value_out;
    logic [1:0]                          status;

    packer_scoreboard sb = new();
    bit tx_gaps = 1'b0;
    bit rx_gaps = 1'b0;
    int hold_req = 0;

    exponent_mantissa_range_packer #(
        .PACKED_BITS  (PACKED_W),
        .MAX_EXPONENT (MAX_EXP)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .packed_word (packed_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .packed_out  (packed_out),
        .value_out   (value_out),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result channel: random stall bursts plus one long hold on request
    initial
    begin
        int  stall_left;
        bit  rdy;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (hold_req > 0) begin
                stall_left = hold_req - 1;
                hold_req = 0;
                rdy = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 16);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_ready <= rdy;
        end
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(packed_out, value_out, status);
    end

    task automatic send_item(input logic k, input logic [31:0] v, input logic [15:0] w);
        pack_item_t it;
        it = '{k, v, w};
        in_valid    <= 1'b1;
        kind        <= k;
        value       <= v;
        packed_word <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_item(it);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Unused field carries noise
    task automatic send_pack(input logic [31:0] v);
        send_item(emrp_pkg::KIND_PACK, v, 16'($urandom));
    endtask

    task automatic send_unpack(input logic [15:0] w);
        send_item(emrp_pkg::KIND_UNPACK, $urandom, w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last beat
    task automatic write_reg(input logic [emrp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [31:0] lo, input logic [31:0] sc,
                              input logic [31:0] st);
        write_reg(emrp_pkg::REG_MIN_VALUE, lo);
        write_reg(emrp_pkg::REG_SCALE, sc);
        write_reg(emrp_pkg::REG_STEP, st);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // Mostly values just above or below the range start, spread over magnitudes
    function automatic logic [31:0] pick_pack_value(logic signed [31:0] lo);
        longint v;
        longint mag;
        mag = longint'($urandom >> $urandom_range(0, 31));
        case ($urandom_range(0, 3))
            0: v = longint'(lo) - 1 - mag;
            1, 2: v = longint'(lo) + mag;
            default: return $urandom;
        endcase
        if (v > VALUE_MAX || v < VALUE_MIN)
            return $urandom;
        return v[31:0];
    endfunction

    task automatic send_random_item();
        logic [15:0] w;
        if ($urandom_range(0, 1) == 0) begin
            send_pack(pick_pack_value(sb.min_value));
        end else begin
            w = 16'($urandom);
            case ($urandom_range(0, 3))
                0: w[EXP_W-1:0] = '0;
                1: w[EXP_W-1:0] = EXP_W'(MAX_EXP);
                default: ;
            endcase
            send_unpack(w);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        kind        <= emrp_pkg::KIND_PACK;
        value       <= '0;
        packed_word <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: range start, unit steps, below range, both extremes
        send_pack(32'h0000_0000);
        send_pack(32'h0000_0001);
        send_pack(32'hFFFF_FFFF);
        send_pack(32'h0001_0000);
        send_pack(32'h0001_8000);
        send_pack(32'h7FFF_FFFF);
        send_pack(32'h8000_0000);
        send_unpack(16'h0000);
        send_unpack(16'h0001);
        send_unpack(16'h000F);
        send_unpack(16'hFFF0);
        send_unpack(16'hFFFF);

        // Full-width range: saturation above range and unpack offset clamp
        wait_drained();
        set_config(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pack(32'h8000_0000);
        send_pack(32'h8000_0001);
        send_pack(32'h7FFF_FFFF);
        send_pack(32'h0000_0000);
        send_unpack(16'h0000);
        send_unpack(16'hFFFF);
        send_unpack(16'h0010);

        // Zero scale and zero step; write to the unused index on the way
        wait_drained();
        write_reg(REG_UNUSED, $urandom);
        set_config(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_pack(32'h8000_0000);
        send_pack(32'h7FFF_FFFF);
        send_unpack(16'hFFFF);
        send_unpack(16'h1234);

        // Random phases, each with its own settings and idle pattern
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained();
            set_config(pick_reg_value(), pick_reg_value(), pick_reg_value());
            tx_gaps = (ph % 3 != 1);
            rx_gaps = (ph % 4 != 2);
            if (ph == HOLD_PHASE) begin
                // sender keeps offering while the result side holds off
                tx_gaps = 1'b0;
                hold_req = HOLD_LEN;
            end
            if (ph == RAND_PHASES - 1) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // no pauses in the final phase
                if (ph != RAND_PHASES - 1 && $urandom_range(0, 149) == 0)
                    wait_drained();
                send_random_item();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.fail_count == 0 && sb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
sv/emrp_pkg.sv
sv/exponent_mantissa_range_packer.sv
bench/exponent_mantissa_range_packer_tb.sv
